### rtl/tms_pkg.sv
`timescale 1ns / 1ps

package tms_pkg;

  localparam int DEF_BUFFER_BYTES = 17;

  // request types
  localparam logic [2:0] REQ_LOAD  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_RETRY = 3'd2;
  localparam logic [2:0] REQ_EVENT = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // bus status codes
  localparam logic [7:0] STATUS_MASK     = 8'hFC;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RESTART      = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK    = 8'h20;
  localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK    = 8'h48;
  localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;
  localparam logic [7:0] ST_NONE         = 8'hF8;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] slot;
    logic [7:0] byte_in;
    logic [6:0] device_address;
    logic       read_flag;
    logic [3:0] message_length;
    logic [7:0] bus_status;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_load;
    logic       ctl_start;
    logic       ctl_stop;
    logic       ctl_ack;
    logic       ctl_go;
    logic       busy_res;
    logic       last_ok;
    logic [7:0] read_data;
    logic       has_error;
    logic [7:0] error_code;
  } result_t;

endpackage

### rtl/tms_buffer.sv
`timescale 1ns / 1ps

module tms_buffer #(
  parameter int BUFFER_BYTES = tms_pkg::DEF_BUFFER_BYTES,
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a write to the same address in the same cycle bypasses to the read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/tms_core.sv
`timescale 1ns / 1ps

module tms_core #(
  parameter int BUFFER_BYTES = tms_pkg::DEF_BUFFER_BYTES,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int CW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             proc,
  input  tms_pkg::item_t   item,
  input  logic [7:0]       buf_data,
  input  tms_pkg::item_t   nxt_item,
  output logic [AW-1:0]    rd_addr,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [7:0]       wr_data,
  output tms_pkg::result_t res
);

  import tms_pkg::*;

  localparam int WW = ((CW > 5) ? CW : 5) + 1;
  localparam logic [WW-1:0] BB_W = WW'(BUFFER_BYTES);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          busy_r, busy_nxt;
  logic          ok_r, ok_nxt;
  logic [7:0]    last_r, last_nxt;

  logic [4:0]    idx;
  logic [4:0]    len;
  logic [WW-1:0] idx_w;
  logic [WW-1:0] len_w;
  logic [WW-1:0] ptr_w;
  logic [WW-1:0] cnt_w;
  logic [WW-1:0] p_w;
  logic [WW-1:0] p1_w;
  logic [7:0]    code;
  logic          idx_ok;
  logic          begin_xfer;
  logic [4:0]    n_idx;
  logic [WW-1:0] n_idx_w;
  logic [7:0]    n_code;

  always_comb begin
    idx    = {1'b0, item.slot} + 5'd1;
    len    = {1'b0, item.message_length} + 5'd1;
    idx_w  = WW'(idx);
    len_w  = WW'(len);
    ptr_w  = WW'(ptr_r);
    cnt_w  = WW'(count_r);
    code   = item.bus_status & STATUS_MASK;
    idx_ok = idx_w < BB_W;
    p_w    = ptr_w;
    p1_w   = ptr_w;

    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    busy_nxt   = busy_r;
    ok_nxt     = ok_r;
    last_nxt   = last_r;
    begin_xfer = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = ptr_r[AW-1:0];
    wr_data    = item.byte_in;

    res = '0;

    unique case (item.req_type)
      REQ_LOAD: begin
        if (!busy_r && idx_ok) begin
          wr_en   = 1'b1;
          wr_addr = idx_w[AW-1:0];
        end
      end
      REQ_START: begin
        if (!busy_r) begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          wr_data    = {item.device_address, item.read_flag};
          count_nxt  = (len_w < BB_W) ? CW'(len_w) : CW'(BUFFER_BYTES);
          begin_xfer = 1'b1;
        end
      end
      REQ_RETRY: begin
        if (!busy_r && ((last_r == ST_SLAW_NACK) || (last_r == ST_SLAR_NACK))) begin
          begin_xfer = 1'b1;
        end
      end
      REQ_EVENT: begin
        if (busy_r) begin
          unique case (code)
            ST_START, ST_RESTART, ST_SLAW_ACK, ST_DATA_TX_ACK: begin
              if ((code == ST_START) || (code == ST_RESTART)) begin
                p_w = '0;
              end
              res.ctl_go = 1'b1;
              if ((p_w < cnt_w) && (p_w < BB_W)) begin
                res.tx_byte = buf_data;
                res.tx_load = 1'b1;
                ptr_nxt     = CW'(p_w + WW'(1));
              end else begin
                ptr_nxt      = CW'(p_w);
                ok_nxt       = 1'b1;
                busy_nxt     = 1'b0;
                res.ctl_stop = 1'b1;
              end
            end
            ST_DATA_RX_ACK, ST_SLAR_ACK: begin
              if ((code == ST_DATA_RX_ACK) && (ptr_w < BB_W)) begin
                wr_en   = 1'b1;
                p1_w    = ptr_w + WW'(1);
                ptr_nxt = CW'(p1_w);
              end
              res.ctl_ack = (p1_w + WW'(1)) < cnt_w;
              res.ctl_go  = 1'b1;
            end
            ST_DATA_RX_NACK: begin
              wr_en        = ptr_w < BB_W;
              ok_nxt       = 1'b1;
              busy_nxt     = 1'b0;
              res.ctl_stop = 1'b1;
              res.ctl_go   = 1'b1;
            end
            ST_ARB_LOST: begin
              res.ctl_start = 1'b1;
              res.ctl_go    = 1'b1;
            end
            default: begin
              last_nxt = code;
              busy_nxt = 1'b0;
            end
          endcase
        end
      end
      REQ_READ: begin
        if (!busy_r && ok_r && idx_ok) begin
          res.read_data = buf_data;
        end
      end
      default: begin
      end
    endcase

    if (begin_xfer) begin
      ok_nxt        = 1'b0;
      last_nxt      = ST_NONE;
      busy_nxt      = 1'b1;
      res.ctl_start = 1'b1;
      res.ctl_go    = 1'b1;
    end

    if (!proc) begin
      count_nxt = count_r;
      ptr_nxt   = ptr_r;
      busy_nxt  = busy_r;
      ok_nxt    = ok_r;
      last_nxt  = last_r;
      wr_en     = 1'b0;
    end

    res.busy_res   = busy_nxt;
    res.last_ok    = ok_nxt;
    res.has_error  = last_nxt != ST_NONE;
    res.error_code = res.has_error ? last_nxt : 8'd0;
  end

  // read address for the transaction being taken in, from the state it will see
  always_comb begin
    n_idx   = {1'b0, nxt_item.slot} + 5'd1;
    n_idx_w = WW'(n_idx);
    n_code  = nxt_item.bus_status & STATUS_MASK;
    if (nxt_item.req_type == REQ_READ) begin
      rd_addr = n_idx_w[AW-1:0];
    end else if ((n_code == ST_START) || (n_code == ST_RESTART)) begin
      rd_addr = '0;
    end else begin
      rd_addr = ptr_nxt[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      busy_r  <= 1'b0;
      ok_r    <= 1'b0;
      last_r  <= ST_NONE;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      busy_r  <= busy_nxt;
      ok_r    <= ok_nxt;
      last_r  <= last_nxt;
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(ptr_r) <= BB_W)
    else $error("byte pointer beyond buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(count_r) <= BB_W)
    else $error("transfer count beyond buffer");

  a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ok_r)
    else $error("transfer marked successful while still running");

endmodule

### rtl/twi_master_transfer_sequencer_unit.sv
`timescale 1ns / 1ps

// I2C master transfer sequencer. One transaction is taken per clock while the output is not
// stalled; its result passes through the input register and the result register. The transfer
// buffer is read at the acceptance edge, at the address the transaction needs given the state
// it will see, so the transaction sits in the input register with its buffer byte ready, and
// the edge that processes it updates the sequencer state and loads the result register.
// Back-to-back transactions run at full rate while the output is not stalled. A stalled
// result holds one further transaction in the input register before in_stall rises. No
// clearing pass after reset: buffer entries read before being written are undefined.
module twi_master_transfer_sequencer_unit #(
  parameter int BUFFER_BYTES = tms_pkg::DEF_BUFFER_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_req_type,
  input  logic [3:0] in_slot,
  input  logic [7:0] in_byte_in,
  input  logic [6:0] in_device_address,
  input  logic       in_read_flag,
  input  logic [3:0] in_message_length,
  input  logic [7:0] in_bus_status,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_load,
  output logic       out_ctl_start,
  output logic       out_ctl_stop,
  output logic       out_ctl_ack,
  output logic       out_ctl_go,
  output logic       out_busy_res,
  output logic       out_last_ok,
  output logic [7:0] out_read_data,
  output logic       out_has_error,
  output logic [7:0] out_error_code
);

  import tms_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  item_t         in_item;
  item_t         item_r;
  logic          item_vld_r, item_vld_nxt;
  result_t       res;
  result_t       res_r;
  logic          out_vld_r, out_vld_nxt;
  logic          res_free;
  logic          proc;
  logic          in_acc;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    buf_data;

  always_comb begin
    in_item.req_type       = in_req_type;
    in_item.slot           = in_slot;
    in_item.byte_in        = in_byte_in;
    in_item.device_address = in_device_address;
    in_item.read_flag      = in_read_flag;
    in_item.message_length = in_message_length;
    in_item.bus_status     = in_bus_status;
  end

  assign res_free = !out_vld_r || !out_stall;
  assign proc     = item_vld_r && res_free;
  assign in_stall = item_vld_r && !res_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_acc) begin
      item_vld_nxt = 1'b1;
    end else if (proc) begin
      item_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r && out_stall;
    if (proc) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item;
    end
    if (proc) begin
      res_r <= res;
    end
  end

  tms_buffer #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_buffer (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (in_acc),
    .rd_addr(rd_addr),
    .rd_data(buf_data)
  );

  tms_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc    (proc),
    .item    (item_r),
    .buf_data(buf_data),
    .nxt_item(in_item),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res     (res)
  );

  assign out_valid      = out_vld_r;
  assign out_tx_byte    = res_r.tx_byte;
  assign out_tx_load    = res_r.tx_load;
  assign out_ctl_start  = res_r.ctl_start;
  assign out_ctl_stop   = res_r.ctl_stop;
  assign out_ctl_ack    = res_r.ctl_ack;
  assign out_ctl_go     = res_r.ctl_go;
  assign out_busy_res   = res_r.busy_res;
  assign out_last_ok    = res_r.last_ok;
  assign out_read_data  = res_r.read_data;
  assign out_has_error  = res_r.has_error;
  assign out_error_code = res_r.error_code;

  a_tx_needs_go: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tx_load) |-> out_ctl_go && out_busy_res)
    else $error("byte loaded without continuing the bus");

  a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ctl_stop) |-> !out_busy_res && out_last_ok)
    else $error("stop requested while transfer still running");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ctl_start) |-> out_busy_res && !out_has_error)
    else $error("start requested while idle or in error");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && !proc) |=> item_vld_r && $stable(item_r))
    else $error("held transaction lost or overwritten");

endmodule
